// ----- rtl/core/mve_pkg.sv -----
// ----------------------------------------------------------------------------
// mve_pkg
// Shared types and constants for the MessagePack value encoder.
// ----------------------------------------------------------------------------
package mve_pkg;

    // Input kind codes.
    localparam logic [3:0] KIND_NIL  = 4'd0;
    localparam logic [3:0] KIND_BOOL = 4'd1;
    localparam logic [3:0] KIND_INT  = 4'd2;
    localparam logic [3:0] KIND_UINT = 4'd3;
    localparam logic [3:0] KIND_DBL  = 4'd4;
    localparam logic [3:0] KIND_STR  = 4'd5;
    localparam logic [3:0] KIND_ARR  = 4'd6;
    localparam logic [3:0] KIND_MAP  = 4'd7;
    localparam logic [3:0] KIND_RAW  = 4'd8;

    // MessagePack marker bytes.
    localparam logic [7:0] MK_NIL    = 8'hC0;
    localparam logic [7:0] MK_FALSE  = 8'hC2;
    localparam logic [7:0] MK_TRUE   = 8'hC3;
    localparam logic [7:0] MK_U8     = 8'hCC;
    localparam logic [7:0] MK_U16    = 8'hCD;
    localparam logic [7:0] MK_U32    = 8'hCE;
    localparam logic [7:0] MK_U64    = 8'hCF;
    localparam logic [7:0] MK_I8     = 8'hD0;
    localparam logic [7:0] MK_I16    = 8'hD1;
    localparam logic [7:0] MK_I32    = 8'hD2;
    localparam logic [7:0] MK_I64    = 8'hD3;
    localparam logic [7:0] MK_DBL    = 8'hCB;
    localparam logic [7:0] MK_FIXSTR = 8'hA0;
    localparam logic [7:0] MK_STR8   = 8'hD9;
    localparam logic [7:0] MK_STR16  = 8'hDA;
    localparam logic [7:0] MK_STR32  = 8'hDB;
    localparam logic [7:0] MK_FIXARR = 8'h90;
    localparam logic [7:0] MK_ARR16  = 8'hDC;
    localparam logic [7:0] MK_ARR32  = 8'hDD;
    localparam logic [7:0] MK_FIXMAP = 8'h80;
    localparam logic [7:0] MK_MAP16  = 8'hDE;
    localparam logic [7:0] MK_MAP32  = 8'hDF;

    // Command queue between classifier and serializer.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    // One classified item: the leading byte, the number of payload bytes
    // behind it and the payload aligned to the top of the word.
    typedef struct packed {
        logic [7:0]  head;
        logic [3:0]  nbytes;
        logic [63:0] data;
    } t_cmd;

endpackage

// ----- rtl/core/msgpack_value_encoder.sv -----
// ----------------------------------------------------------------------------
// msgpack_value_encoder
// Encodes one typed value per request into its MessagePack byte sequence.
// ----------------------------------------------------------------------------
// Each input request carries a kind (nil, bool, signed int, unsigned int,
// double, string header, array header, map header or raw byte) and a 64-bit
// value. The block returns the MessagePack encoding of that value one byte per
// result request, most significant byte first, with last set on the final
// byte. Integers take the shortest form, lengths keep only their low 32 bits,
// and an unused kind is accepted and produces no bytes. The output side moves
// one byte per clock while pop keeps taking them; that single byte lane sets
// the sustained rate for items of 1 to 9 encoded bytes. The input side accepts
// a new request in any cycle in which full is low, even while earlier items
// are still being sent, because a four-entry command queue sits between the
// classifier and the serializer. The first byte passes through the queue and
// then the output register before it appears on the result ports. There is no
// configuration and no state is kept between items.
// ----------------------------------------------------------------------------
module msgpack_value_encoder
    import mve_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  i_kind,
    input  logic [63:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    logic cls_valid;
    t_cmd cls_cmd;
    t_cmd q_cmd;
    logic q_empty;
    logic q_pop;

    // Front end: choose the marker and payload length for the item.
    mve_classify u_classify (
        .i_kind  (i_kind),
        .i_value (i_value),
        .o_valid (cls_valid),
        .o_cmd   (cls_cmd)
    );

    // Items of an unused kind are accepted but never enter the queue.
    mve_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && cls_valid),
        .i_cmd   (cls_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_empty (q_empty)
    );

    // Back end: stream the marker and payload bytes.
    mve_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

// ----- rtl/core/mve_classify.sv -----
// ----------------------------------------------------------------------------
// mve_classify
// Front end: picks the shortest MessagePack form for one value item.
// ----------------------------------------------------------------------------
module mve_classify
    import mve_pkg::*;
(
    input  logic [3:0]  i_kind,
    input  logic [63:0] i_value,
    output logic        o_valid,
    output t_cmd        o_cmd
);

    logic [31:0] len;
    logic [3:0]  nbytes;
    logic [7:0]  head;

    assign len = i_value[31:0];

    always_comb begin
        o_valid = 1'b1;
        head    = MK_NIL;
        nbytes  = 4'd0;
        case (i_kind)
            KIND_NIL: begin
                head = MK_NIL;
            end
            KIND_BOOL: begin
                head = i_value[0] ? MK_TRUE : MK_FALSE;
            end
            KIND_INT, KIND_UINT: begin
                if ((i_kind == KIND_UINT) || !i_value[63]) begin
                    if (~|i_value[63:7]) begin
                        head = i_value[7:0];
                    end else if (~|i_value[63:8]) begin
                        head = MK_U8;  nbytes = 4'd1;
                    end else if (~|i_value[63:16]) begin
                        head = MK_U16; nbytes = 4'd2;
                    end else if (~|i_value[63:32]) begin
                        head = MK_U32; nbytes = 4'd4;
                    end else begin
                        head = MK_U64; nbytes = 4'd8;
                    end
                end else begin
                    if (&i_value[63:5]) begin
                        head = i_value[7:0];
                    end else if (&i_value[63:7]) begin
                        head = MK_I8;  nbytes = 4'd1;
                    end else if (&i_value[63:15]) begin
                        head = MK_I16; nbytes = 4'd2;
                    end else if (&i_value[63:31]) begin
                        head = MK_I32; nbytes = 4'd4;
                    end else begin
                        head = MK_I64; nbytes = 4'd8;
                    end
                end
            end
            KIND_DBL: begin
                head = MK_DBL; nbytes = 4'd8;
            end
            KIND_STR: begin
                if (~|len[31:5]) begin
                    head = MK_FIXSTR | {3'b000, len[4:0]};
                end else if (~|len[31:8]) begin
                    head = MK_STR8;  nbytes = 4'd1;
                end else if (~|len[31:16]) begin
                    head = MK_STR16; nbytes = 4'd2;
                end else begin
                    head = MK_STR32; nbytes = 4'd4;
                end
            end
            KIND_ARR, KIND_MAP: begin
                if (~|len[31:4]) begin
                    head = ((i_kind == KIND_ARR) ? MK_FIXARR : MK_FIXMAP)
                         | {4'b0000, len[3:0]};
                end else if (~|len[31:16]) begin
                    head = (i_kind == KIND_ARR) ? MK_ARR16 : MK_MAP16;
                    nbytes = 4'd2;
                end else begin
                    head = (i_kind == KIND_ARR) ? MK_ARR32 : MK_MAP32;
                    nbytes = 4'd4;
                end
            end
            KIND_RAW: begin
                head = i_value[7:0];
            end
            default: begin
                // Unused kinds are taken and dropped.
                o_valid = 1'b0;
            end
        endcase
    end

    // Left-align the payload so the serializer always takes the top byte.
    always_comb begin
        o_cmd.head   = head;
        o_cmd.nbytes = nbytes;
        case (nbytes)
            4'd1:    o_cmd.data = {i_value[7:0], 56'd0};
            4'd2:    o_cmd.data = {i_value[15:0], 48'd0};
            4'd4:    o_cmd.data = {i_value[31:0], 32'd0};
            default: o_cmd.data = i_value;
        endcase
    end

endmodule

// ----- rtl/core/mve_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// mve_cmd_fifo
// Short command queue that decouples the classifier from the serializer.
// ----------------------------------------------------------------------------
module mve_cmd_fifo
    import mve_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_PTR_W:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == CMD_PTR_W'(0) + (CMD_PTR_W+1)'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + CMD_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + CMD_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (CMD_PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (CMD_PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/mve_serializer.sv -----
// ----------------------------------------------------------------------------
// mve_serializer
// Back end: sends each command as a stream of bytes through an output register.
// ----------------------------------------------------------------------------
module mve_serializer
    import mve_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_empty,
    output logic       o_cmd_pop,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_empty,
    input  logic       i_pop
);

    logic        r_busy;
    logic [3:0]  r_left;
    logic [63:0] r_data;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_last;

    logic        n_busy;
    logic [3:0]  n_left;
    logic [63:0] n_data;
    logic        n_out_valid;
    logic [7:0]  n_out_byte;
    logic        n_last;
    logic        advance;

    // The output slot moves on when it is empty or its byte is taken.
    assign advance = !r_out_valid || i_pop;

    always_comb begin
        n_busy      = r_busy;
        n_left      = r_left;
        n_data      = r_data;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_last      = r_last;
        o_cmd_pop   = 1'b0;
        if (advance) begin
            if (r_busy) begin
                n_out_valid = 1'b1;
                n_out_byte  = r_data[63:56];
                n_last      = (r_left == 4'd1);
                n_data      = {r_data[55:0], 8'd0};
                n_left      = r_left - 4'd1;
                n_busy      = (r_left != 4'd1);
            end else if (!i_cmd_empty) begin
                // The leading byte goes straight out of the queue head.
                o_cmd_pop   = 1'b1;
                n_out_valid = 1'b1;
                n_out_byte  = i_cmd.head;
                n_last      = (i_cmd.nbytes == 4'd0);
                n_busy      = (i_cmd.nbytes != 4'd0);
                n_left      = i_cmd.nbytes;
                n_data      = i_cmd.data;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left     <= n_left;
        r_data     <= n_data;
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
    end

    assign o_out_byte = r_out_byte;
    assign o_last     = r_last;
    assign o_empty    = !r_out_valid;

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_left != 4'd0) && (r_left <= 4'd8))
        else $error("payload count out of range while busy");

    a_busy_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_out_valid)
        else $error("payload pending but output slot empty");

    a_last_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && advance) |=> r_out_valid && (o_last == ($past(r_left) == 4'd1)))
        else $error("last flag does not match payload count");

    a_no_load_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> !r_busy && !i_cmd_empty)
        else $error("command taken while previous one is still sending");

endmodule
